// ===== rtl/ntp_pkg.sv =====
`default_nettype none
package ntp_pkg;
  localparam int NumContexts = 8;
  localparam int StackDepth  = 16;
  localparam int CtxW        = 3;
  localparam int SpW         = 5;

  localparam logic [2:0] CMD_BEGIN     = 3'd0;
  localparam logic [2:0] CMD_END       = 3'd1;
  localparam logic [2:0] CMD_END_LOOP  = 3'd2;
  localparam logic [2:0] CMD_RD_USAGE  = 3'd3;
  localparam logic [2:0] CMD_RD_MAX    = 3'd4;
  localparam logic [2:0] CMD_RD_LAST   = 3'd5;
  localparam logic [2:0] CMD_RD_ONGO   = 3'd6;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;
  localparam logic [1:0] ST_ZERODIV   = 2'd3;

  localparam logic [31:0] PerMille = 32'd1000;
  localparam logic [31:0] PerMillion = 32'd1000000;
endpackage
`default_nettype wire

// ===== rtl/nested_task_time_profiler.sv =====
`default_nettype none
// Preemption-aware per-context time profiler. One request per command; every request
// gives exactly one response (value, status, debug pin mask). Simple commands are
// executed in S_EXEC and answered from S_OUT. end_loop and read_usage_reset form the
// product in S_EXEC, load the shared restoring divider in S_MUL, then run it one
// quotient bit a cycle for 64 steps in S_DIV and saturate the result in S_FIN before
// S_OUT; a zero divisor skips the division. The block takes no new request until the
// response has been taken.
module nested_task_time_profiler (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [71:0] in_tdata,   // cmd[2:0], context_req[5:3], timestamp[37:6], loop_duration[69:38]
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [47:0] out_tdata   // value[31:0], status[33:32], debug_pins[41:34]
);
  import ntp_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0, S_EXEC = 3'd1, S_MUL = 3'd2, S_DIV = 3'd3,
                         S_FIN = 3'd4, S_OUT = 3'd5;

  logic [2:0]  state_r;
  logic [2:0]  cmd_r;
  logic [CtxW-1:0] ctx_r;
  logic [31:0] ts_r, dur_r;
  logic [CtxW-1:0] run_stack_r [StackDepth];
  logic [SpW-1:0]  sp_r;
  logic [31:0] start_r [NumContexts];
  logic [31:0] seg_r   [NumContexts];
  logic [31:0] tot_r   [NumContexts];
  logic [31:0] loop_r  [NumContexts];
  logic [31:0] last_r  [NumContexts];
  logic [31:0] max_r   [NumContexts];
  logic [31:0] lrt_r   [NumContexts];
  logic [NumContexts-1:0] meas_r;
  logic [31:0] value_r;
  logic [1:0]  status_r;
  // divider state
  logic [63:0] num_r;
  logic [31:0] rem_r;
  logic [31:0] den_r;
  logic [6:0]  cnt_r;
  logic [63:0] prod_r;

  logic [2:0]  cmd_in;
  logic [CtxW-1:0] ctx_in;
  logic [CtxW-1:0] top;
  logic [31:0] seg_end;
  logic [32:0] rem_sh;
  logic [33:0] trial;

  assign cmd_in = in_tdata[2:0];
  assign ctx_in = in_tdata[5:3];
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata  = {6'd0, meas_r, status_r, value_r};
  assign top     = run_stack_r[sp_r[3:0] - 4'd1];
  assign seg_end = seg_r[ctx_r] + (ts_r - start_r[ctx_r]);
  assign rem_sh  = {rem_r, num_r[63]};
  assign trial   = {1'b0, rem_sh} - {2'b0, den_r};

  // stack entries are written only on push
  always_ff @(posedge clk) begin
    if (state_r == S_EXEC && cmd_r == CMD_BEGIN && sp_r < SpW'(StackDepth))
      run_stack_r[sp_r[3:0]] <= ctx_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sp_r    <= '0;
      meas_r  <= '0;
      for (int i = 0; i < NumContexts; i++) begin
        start_r[i] <= '0; seg_r[i] <= '0; tot_r[i] <= '0; loop_r[i] <= '0;
        last_r[i] <= '0; max_r[i] <= '0; lrt_r[i] <= '0;
      end
    end else begin
      unique case (state_r)
        S_IDLE: if (in_tvalid) begin
          cmd_r <= cmd_in; ctx_r <= ctx_in;
          ts_r <= in_tdata[37:6]; dur_r <= in_tdata[69:38];
          state_r <= S_EXEC;
        end
        // simple commands and setup of the long ones
        S_EXEC: begin
          unique case (cmd_r)
            CMD_BEGIN: begin
              value_r <= '0; state_r <= S_OUT;
              if (sp_r >= SpW'(StackDepth)) status_r <= ST_OVERFLOW;
              else begin
                status_r <= ST_OK;
                if (sp_r != '0 && top != ctx_r)
                  seg_r[top] <= seg_r[top] + (ts_r - start_r[top]);
                sp_r <= sp_r + 1'b1;
                start_r[ctx_r] <= ts_r;
                seg_r[ctx_r] <= '0;
                meas_r[ctx_r] <= 1'b1;
              end
            end
            CMD_END: begin
              value_r <= '0; state_r <= S_OUT;
              if (sp_r == '0) status_r <= ST_UNDERFLOW;
              else begin
                status_r <= ST_OK;
                meas_r[ctx_r] <= 1'b0;
                sp_r <= sp_r - 1'b1;
                seg_r[ctx_r] <= seg_end;
                tot_r[ctx_r] <= tot_r[ctx_r] + seg_end;
                loop_r[ctx_r] <= loop_r[ctx_r] + seg_end;
                if (sp_r > SpW'(1)) start_r[run_stack_r[sp_r[3:0] - 4'd2]] <= ts_r;
              end
            end
            CMD_END_LOOP: begin
              value_r <= '0; status_r <= ST_OK;
              prod_r <= 64'(loop_r[ctx_r]) * 64'(PerMille);
              loop_r[ctx_r] <= '0;
              den_r <= dur_r;
              state_r <= S_MUL;
            end
            CMD_RD_USAGE: begin
              value_r <= '0; status_r <= ST_OK;
              prod_r <= 64'(tot_r[ctx_r]) * 64'(PerMillion);
              den_r <= ts_r - lrt_r[ctx_r];
              tot_r[ctx_r] <= '0;
              lrt_r[ctx_r] <= ts_r;
              state_r <= S_MUL;
            end
            CMD_RD_MAX: begin
              value_r <= max_r[ctx_r]; max_r[ctx_r] <= '0;
              status_r <= ST_OK; state_r <= S_OUT;
            end
            CMD_RD_LAST: begin
              value_r <= last_r[ctx_r]; last_r[ctx_r] <= '0;
              status_r <= ST_OK; state_r <= S_OUT;
            end
            CMD_RD_ONGO: begin
              value_r <= meas_r[ctx_r] ? seg_end : '0;
              status_r <= ST_OK; state_r <= S_OUT;
            end
            default: begin
              value_r <= '0; status_r <= ST_OK; state_r <= S_OUT;
            end
          endcase
        end
        // registered product feeds the divider
        S_MUL: begin
          if (cmd_r == CMD_END_LOOP && prod_r[63:32] != '0) num_r <= 64'hFFFF_FFFF;
          else num_r <= prod_r;
          rem_r <= '0; cnt_r <= '0;
          if (den_r == '0) begin
            status_r <= ST_ZERODIV;
            if (cmd_r == CMD_END_LOOP) last_r[ctx_r] <= '0;
            state_r <= S_OUT;
          end else state_r <= S_DIV;
        end
        // restoring division, one bit a cycle; quotient shifts into num_r
        S_DIV: begin
          if (!trial[33]) begin
            rem_r <= trial[31:0]; num_r <= {num_r[62:0], 1'b1};
          end else begin
            rem_r <= rem_sh[31:0]; num_r <= {num_r[62:0], 1'b0};
          end
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == 7'd63) state_r <= S_FIN;
        end
        S_FIN: begin
          value_r <= (num_r[63:32] != '0) ? 32'hFFFF_FFFF : num_r[31:0];
          if (cmd_r == CMD_END_LOOP) begin
            last_r[ctx_r] <= num_r[31:0];
            if (num_r[31:0] > max_r[ctx_r]) max_r[ctx_r] <= num_r[31:0];
          end
          state_r <= S_OUT;
        end
        S_OUT: if (out_tready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
